[design/scan_polar_to_cartesian_unit_assert.svh]
// Assertion macros for the scan polar-to-Cartesian unit.
// Included by the top level; depends on clk_i and rst_ni being in scope.
`ifndef SCAN_POLAR_TO_CARTESIAN_UNIT_ASSERT_SVH
`define SCAN_POLAR_TO_CARTESIAN_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/spc_pkg.sv]
// Shared types and constants for the scan polar-to-Cartesian unit.
// No dependencies; used by every module of the block.
package spc_pkg;

  localparam int RANGE_W   = 16;
  localparam int BEAM_W    = 12;
  localparam int ANGLE_W   = 32;
  localparam int HEAD_W    = 9;
  localparam int OUT_W     = 17;
  localparam int XW        = 34;
  localparam int ZW        = 34;
  localparam int GUARD     = 14;
  localparam int ATAN_MAX  = 24;
  localparam int X0_W      = 30;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [29:0] GAIN_Q30 = 30'd652032874;
  // Whole degrees to angle units: 2^32 = 360 * HEAD_INT + 256.
  localparam logic [23:0] HEAD_INT = 24'd11930464;
  localparam logic [7:0]  HEAD_RND = 8'd180;
  // floor(v / 360) = (v * HEAD_RECIP) >> HEAD_SHIFT for v below 2^17.
  localparam logic [17:0] HEAD_RECIP = 18'd186414;
  localparam int          HEAD_SHIFT = 26;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 17'sd65535;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -17'sd65536;

  localparam logic [1:0] REG_ANGLE_START = 2'd0;
  localparam logic [1:0] REG_ANGLE_STEP  = 2'd1;
  localparam logic [1:0] REG_HEADING     = 2'd2;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 no_ret;
    logic [BEAM_W-1:0]    beam;
    logic                 last;
  } cord_t;

  function automatic logic [ANGLE_W-1:0] atan_bau(input int unsigned idx);
    logic [ANGLE_W-1:0] v;
    case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[design/scan_polar_to_cartesian_unit.sv]
// Scan polar-to-Cartesian unit: top level with register port and CORDIC pipeline.
// Depends on spc_pkg, spc_angle_front, spc_cordic_stage, spc_out_stage.
//
// Each beam word yields one point word, in order, with x = range*cos and
// y = range*sin of start + index*step + heading, in signed Q6.10 metres.
// The pipeline takes one word per clock while the output is not held; it has
// two front-end stages, one register per CORDIC iteration and one output
// register, with the iteration count capped at 24. When the output word is
// held by the consumer, the whole pipeline holds and in_ready_o drops.
// Registers at byte addresses 0, 4, 8: angle_start, angle_step, heading_deg.
// Write them only while no words are in flight.
module scan_polar_to_cartesian_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [spc_pkg::ADDR_W-1:0]         paddr,
  input  logic [spc_pkg::DATA_W-1:0]         pwdata,
  output logic [spc_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [spc_pkg::RANGE_W-1:0]        range_value_i,
  input  logic                               no_return_i,
  input  logic [spc_pkg::BEAM_W-1:0]         beam_index_i,
  input  logic                               scan_end_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [spc_pkg::OUT_W-1:0]   x_coord_o,
  output logic signed [spc_pkg::OUT_W-1:0]   y_coord_o,
  output logic                               point_valid_o,
  output logic [spc_pkg::BEAM_W-1:0]         beam_out_o,
  output logic                               last_point_o
);
  import spc_pkg::*;

  `include "scan_polar_to_cartesian_unit_assert.svh"

  localparam int NSTG = (CORDIC_STAGES > ATAN_MAX) ? ATAN_MAX : CORDIC_STAGES;

  logic [ANGLE_W-1:0] angle_start_q;
  logic [ANGLE_W-1:0] angle_step_q;
  logic [HEAD_W-1:0]  heading_q;
  logic               wr_en;
  logic               en;

  logic               valid_c [NSTG+1];
  cord_t              data_c  [NSTG+1];

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_start_q <= '0;
      angle_step_q  <= '0;
      heading_q     <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_ANGLE_START: angle_start_q <= pwdata;
        REG_ANGLE_STEP:  angle_step_q  <= pwdata;
        REG_HEADING:     heading_q     <= pwdata[HEAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ANGLE_START: prdata = angle_start_q;
      REG_ANGLE_STEP:  prdata = angle_step_q;
      REG_HEADING:     prdata = {{(DATA_W-HEAD_W){1'b0}}, heading_q};
      default:         prdata = '0;
    endcase
  end

  assign en         = ~out_valid_o | out_ready_i;
  assign in_ready_o = en;

  spc_angle_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (in_valid_i),
    .range_value_i (range_value_i),
    .no_return_i   (no_return_i),
    .beam_index_i  (beam_index_i),
    .scan_end_i    (scan_end_i),
    .angle_start_i (angle_start_q),
    .angle_step_i  (angle_step_q),
    .heading_i     (heading_q),
    .valid_o       (valid_c[0]),
    .data_o        (data_c[0])
  );

  for (genvar g = 0; g < NSTG; g++) begin : g_cordic
    spc_cordic_stage #(
      .SHIFT (g)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_c[g]),
      .data_i  (data_c[g]),
      .valid_o (valid_c[g+1]),
      .data_o  (data_c[g+1])
    );
  end

  spc_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (valid_c[NSTG]),
    .data_i        (data_c[NSTG]),
    .valid_o       (out_valid_o),
    .x_coord_o     (x_coord_o),
    .y_coord_o     (y_coord_o),
    .point_valid_o (point_valid_o),
    .beam_out_o    (beam_out_o),
    .last_point_o  (last_point_o)
  );

  `SPC_ASSERT_IMPL(a_noret_zero, out_valid_o && !point_valid_o, (x_coord_o == '0) && (y_coord_o == '0), "no-return word has nonzero coordinates")
  `SPC_ASSERT_NEXT(a_last_stage_moves, en && valid_c[NSTG], out_valid_o && (beam_out_o == $past(data_c[NSTG].beam)) && (last_point_o == $past(data_c[NSTG].last)), "word lost between CORDIC chain and output")
  `SPC_ASSERT_NEXT(a_heading_write, wr_en && (paddr[3:2] == REG_HEADING), heading_q == $past(pwdata[HEAD_W-1:0]), "heading register write not taken")

endmodule

[design/spc_angle_front.sv]
// Front end: beam angle, heading conversion, gain-scaled range and half-turn fold.
// Two register stages; depends on spc_pkg.
module spc_angle_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [spc_pkg::RANGE_W-1:0]   range_value_i,
  input  logic                          no_return_i,
  input  logic [spc_pkg::BEAM_W-1:0]    beam_index_i,
  input  logic                          scan_end_i,
  input  logic [spc_pkg::ANGLE_W-1:0]   angle_start_i,
  input  logic [spc_pkg::ANGLE_W-1:0]   angle_step_i,
  input  logic [spc_pkg::HEAD_W-1:0]    heading_i,
  output logic                          valid_o,
  output spc_pkg::cord_t                data_o
);
  import spc_pkg::*;

  logic                 s1_valid_q;
  logic [ANGLE_W-1:0]   prod_q, prod_d;
  logic [ANGLE_W-1:0]   hmul_q, hmul_d;
  logic [HEAD_W-1:0]    hq_q, hq_d;
  logic [X0_W-1:0]      x0_q, x0_d;
  logic                 s1_noret_q;
  logic [BEAM_W-1:0]    s1_beam_q;
  logic                 s1_last_q;

  logic [43:0]          prod_full;
  logic [32:0]          hmul_full;
  logic [16:0]          hv;
  logic [34:0]          hq_full;
  logic [45:0]          x0_full;

  logic                 s2_valid_q;
  cord_t                s2_q, s2_d;
  logic [ANGLE_W-1:0]   ang;
  logic [ANGLE_W-1:0]   ang_f;
  logic                 flip;

  always_comb begin
    prod_full = {32'd0, beam_index_i} * {12'd0, angle_step_i};
    prod_d    = prod_full[ANGLE_W-1:0];
    hmul_full = {24'd0, heading_i} * {9'd0, HEAD_INT};
    hmul_d    = hmul_full[ANGLE_W-1:0];
    hv        = {heading_i, 8'd0} + {9'd0, HEAD_RND};
    hq_full   = {18'd0, hv} * {17'd0, HEAD_RECIP};
    hq_d      = hq_full[HEAD_SHIFT +: HEAD_W];
    x0_full   = {30'd0, range_value_i} * {16'd0, GAIN_Q30};
    x0_d      = x0_full[45:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q     <= prod_d;
      hmul_q     <= hmul_d;
      hq_q       <= hq_d;
      x0_q       <= x0_d;
      s1_noret_q <= no_return_i;
      s1_beam_q  <= beam_index_i;
      s1_last_q  <= scan_end_i;
    end
  end

  always_comb begin
    ang   = angle_start_i + prod_q + hmul_q + {{(ANGLE_W-HEAD_W){1'b0}}, hq_q};
    flip  = ang[31] ^ ang[30];
    ang_f = {ang[31] ^ flip, ang[30:0]};
    s2_d.x      = flip ? -$signed({{(XW-X0_W){1'b0}}, x0_q})
                       : $signed({{(XW-X0_W){1'b0}}, x0_q});
    s2_d.y      = '0;
    s2_d.z      = $signed({{(ZW-ANGLE_W){ang_f[31]}}, ang_f});
    s2_d.no_ret = s1_noret_q;
    s2_d.beam   = s1_beam_q;
    s2_d.last   = s1_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign data_o  = s2_q;

endmodule

[design/spc_cordic_stage.sv]
// One registered rotation-mode CORDIC iteration with a fixed shift.
// Depends on spc_pkg for the word type and the arctangent table.
module spc_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  spc_pkg::cord_t data_i,
  output logic           valid_o,
  output spc_pkg::cord_t data_o
);
  import spc_pkg::*;

  localparam logic [ANGLE_W-1:0] ATAN = atan_bau(SHIFT);

  logic                 valid_q;
  cord_t                data_q, data_d;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] da;

  always_comb begin
    dx     = $signed(data_i.y) >>> SHIFT;
    dy     = $signed(data_i.x) >>> SHIFT;
    da     = $signed({{(ZW-ANGLE_W){1'b0}}, ATAN});
    data_d = data_i;
    if (!data_i.z[ZW-1]) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - da;
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + da;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[design/spc_out_stage.sv]
// Output register: rounds and saturates the coordinates, applies the no-return flag.
// Depends on spc_pkg.
module spc_out_stage (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  spc_pkg::cord_t                     data_i,
  output logic                               valid_o,
  output logic signed [spc_pkg::OUT_W-1:0]   x_coord_o,
  output logic signed [spc_pkg::OUT_W-1:0]   y_coord_o,
  output logic                               point_valid_o,
  output logic [spc_pkg::BEAM_W-1:0]         beam_out_o,
  output logic                               last_point_o
);
  import spc_pkg::*;

  localparam int RW = XW - GUARD;

  logic                    valid_q;
  logic signed [OUT_W-1:0] x_q, x_d;
  logic signed [OUT_W-1:0] y_q, y_d;
  logic                    pv_q;
  logic [BEAM_W-1:0]       beam_q;
  logic                    last_q;
  logic signed [XW-1:0]    xr;
  logic signed [XW-1:0]    yr;
  logic signed [RW-1:0]    xs;
  logic signed [RW-1:0]    ys;

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [RW-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > $signed({{(RW-OUT_W){1'b0}}, OUT_MAX})) begin
      r = OUT_MAX;
    end else if (v < $signed({{(RW-OUT_W){1'b1}}, OUT_MIN})) begin
      r = OUT_MIN;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    xr  = data_i.x + $signed(XW'(1) <<< (GUARD - 1));
    yr  = data_i.y + $signed(XW'(1) <<< (GUARD - 1));
    xs  = RW'(xr >>> GUARD);
    ys  = RW'(yr >>> GUARD);
    x_d = data_i.no_ret ? '0 : sat(xs);
    y_d = data_i.no_ret ? '0 : sat(ys);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      pv_q   <= ~data_i.no_ret;
      beam_q <= data_i.beam;
      last_q <= data_i.last;
    end
  end

  assign valid_o       = valid_q;
  assign x_coord_o     = x_q;
  assign y_coord_o     = y_q;
  assign point_valid_o = pv_q;
  assign beam_out_o    = beam_q;
  assign last_point_o  = last_q;

endmodule
